FILE: rtl/acl_pkg.sv
`timescale 1ns / 1ps

package acl_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int PADDR_BITS_DEF = 32;
    localparam int HW_BITS_DEF    = 48;

    localparam int STAMP_W   = 32;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int PROTO_W   = 16;
    localparam int ACT_W     = 3;
    localparam int REQ_W     = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_DROP     = 3'd0,
        ACT_HIT      = 3'd1,
        ACT_MISS     = 3'd2,
        ACT_REPLY    = 3'd3,
        ACT_LEARNED  = 3'd4,
        ACT_SPOOF    = 3'd5,
        ACT_DISABLED = 3'd6
    } action_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP  = 2'd0,
        REQ_REQUEST = 2'd1,
        REQ_REPLY   = 2'd2,
        REQ_OTHER   = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED    = 2'd0,
        CFG_PROTO_TYPE = 2'd1,
        CFG_MY_PADDR   = 2'd2,
        CFG_MY_HWADDR  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic clr;
        logic vld;
    } scan_ctl_t;

endpackage

FILE: rtl/acl_store.sv
`timescale 1ns / 1ps

module acl_store #(
    parameter int ENTRIES    = acl_pkg::ENTRIES_DEF,
    parameter int PADDR_BITS = acl_pkg::PADDR_BITS_DEF,
    parameter int HW_BITS    = acl_pkg::HW_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        we,
    input  logic [$clog2(ENTRIES)-1:0]  waddr,
    input  logic [PADDR_BITS-1:0]       wpaddr,
    input  logic [HW_BITS-1:0]          whw,
    input  logic [acl_pkg::STAMP_W-1:0] wstamp,
    input  logic                        re,
    input  logic [$clog2(ENTRIES)-1:0]  raddr,
    output logic [PADDR_BITS-1:0]       rpaddr,
    output logic [HW_BITS-1:0]          rhw,
    output logic [acl_pkg::STAMP_W-1:0] rstamp
);
    import acl_pkg::*;

    localparam int WORD_W = STAMP_W + HW_BITS + PADDR_BITS;

    logic [WORD_W-1:0]  mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [WORD_W-1:0]  rd_word_reg;
    logic               rd_valid_reg;

    // valid bits stand in for clearing the address column at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wstamp, whw, wpaddr};
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_word_reg  <= mem[raddr];
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    assign rpaddr = rd_valid_reg ? rd_word_reg[PADDR_BITS-1:0] : '0;
    assign rhw    = rd_word_reg[PADDR_BITS +: HW_BITS];
    assign rstamp = rd_word_reg[PADDR_BITS + HW_BITS +: STAMP_W];

endmodule

FILE: rtl/acl_scan.sv
`timescale 1ns / 1ps

module acl_scan #(
    parameter int ENTRIES    = acl_pkg::ENTRIES_DEF,
    parameter int PADDR_BITS = acl_pkg::PADDR_BITS_DEF,
    parameter int HW_BITS    = acl_pkg::HW_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  acl_pkg::scan_ctl_t          ctl,
    input  logic [$clog2(ENTRIES)-1:0]  k,
    input  logic [PADDR_BITS-1:0]       key,
    input  logic [acl_pkg::STAMP_W-1:0] use_clock,
    input  logic [PADDR_BITS-1:0]       rpaddr,
    input  logic [HW_BITS-1:0]          rhw,
    input  logic [acl_pkg::STAMP_W-1:0] rstamp,
    output logic                        found,
    output logic [$clog2(ENTRIES)-1:0]  match_idx,
    output logic [HW_BITS-1:0]          match_hw,
    output logic [acl_pkg::STAMP_W-1:0] match_stamp,
    output logic [$clog2(ENTRIES)-1:0]  pick_idx
);
    import acl_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    logic               found_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic [HW_BITS-1:0] match_hw_reg;
    logic [STAMP_W-1:0] match_stamp_reg;
    logic [IDX_W-1:0]   pick_idx_reg;
    logic [STAMP_W-1:0] pick_age_reg;
    logic [STAMP_W-1:0] age_k;
    logic               hit_k;
    logic               empty_k;
    logic               take_k;

    always_comb
    begin
        age_k   = use_clock - rstamp;
        hit_k   = (rpaddr == key);
        empty_k = (rpaddr == '0);
        // an empty entry always wins: its age counts as the largest possible
        take_k  = (k == '0) || empty_k || (age_k > pick_age_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clr)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.vld && hit_k)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.vld)
        begin
            if (hit_k && !found_reg)
            begin
                match_idx_reg   <= k;
                match_hw_reg    <= rhw;
                match_stamp_reg <= rstamp;
            end
            if (take_k)
            begin
                pick_idx_reg <= k;
                pick_age_reg <= empty_k ? '1 : age_k;
            end
        end
    end

    assign found       = found_reg;
    assign match_idx   = match_idx_reg;
    assign match_hw    = match_hw_reg;
    assign match_stamp = match_stamp_reg;
    assign pick_idx    = pick_idx_reg;

endmodule

FILE: rtl/arp_cache_lru_responder_top.sv
`timescale 1ns / 1ps

// address-resolution cache with least-recently-used eviction. one item at a time:
// raise start while busy is low; the single result shows on action, hw_addr and
// paddr_out for exactly one cycle with done high and cannot be held off. items decided
// from configuration alone (disabled, lookup of zero or of our own address, dropped or
// spoofed frames) end in the check state; other lookups and accepted frames pass scan,
// drain and finish: the entry memory is read one entry per cycle through its single
// read port, then finish writes back any update. the cache leaves reset empty at once,
// via per-entry valid bits, with no clearing pass. the user must write configuration
// only while busy is low and no done is pending; the block does not enforce it.
module arp_cache_lru_responder_top #(
    parameter int ENTRIES    = acl_pkg::ENTRIES_DEF,
    parameter int PADDR_BITS = acl_pkg::PADDR_BITS_DEF,
    parameter int HW_BITS    = acl_pkg::HW_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [acl_pkg::REQ_W-1:0]     req_type,
    input  logic [acl_pkg::PROTO_W-1:0]   frame_proto,
    input  logic [PADDR_BITS-1:0]         sender_paddr,
    input  logic [HW_BITS-1:0]            sender_hw,
    input  logic [PADDR_BITS-1:0]         target_paddr,
    input  logic [HW_BITS-1:0]            target_hw,
    input  logic                          cfg_we,
    input  logic [acl_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [acl_pkg::CFG_W-1:0]     cfg_wdata,
    output logic                          done,
    output logic [acl_pkg::ACT_W-1:0]     action,
    output logic [HW_BITS-1:0]            hw_addr,
    output logic [PADDR_BITS-1:0]         paddr_out
);
    import acl_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic                done_reg, done_next;
    action_t             action_reg, action_next;
    logic [HW_BITS-1:0]  hw_out_reg, hw_out_next;
    logic [PADDR_BITS-1:0] pa_out_reg, pa_out_next;
    logic [STAMP_W-1:0]  use_clock_reg, use_clock_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]    rd_k_reg, rd_k_next;

    logic                enabled_reg;
    logic [PROTO_W-1:0]  proto_type_reg;
    logic [31:0]         my_paddr_reg;
    logic [CFG_W-1:0]    my_hwaddr_reg;

    req_t                req_reg;
    logic [PROTO_W-1:0]  fproto_reg;
    logic [PADDR_BITS-1:0] spa_reg;
    logic [HW_BITS-1:0]  shw_reg;
    logic [PADDR_BITS-1:0] tpa_reg;
    logic [HW_BITS-1:0]  thw_reg;

    logic [PADDR_BITS-1:0] mine;
    logic [HW_BITS-1:0]  mine_hw;
    logic                is_lookup;
    logic [PADDR_BITS-1:0] key;
    logic                accept;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [PADDR_BITS-1:0] mem_wpaddr;
    logic [HW_BITS-1:0]  mem_whw;
    logic [STAMP_W-1:0]  mem_wstamp;
    logic                mem_re;
    logic [PADDR_BITS-1:0] rpaddr;
    logic [HW_BITS-1:0]  rhw;
    logic [STAMP_W-1:0]  rstamp;

    scan_ctl_t           scan_ctl;
    logic                scan_found;
    logic [IDX_W-1:0]    scan_match_idx;
    logic [HW_BITS-1:0]  scan_match_hw;
    logic [STAMP_W-1:0]  scan_match_stamp;
    logic [IDX_W-1:0]    scan_pick_idx;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign mine      = PADDR_BITS'(my_paddr_reg);
    assign mine_hw   = HW_BITS'(my_hwaddr_reg);
    assign is_lookup = (req_reg == REQ_LOOKUP);
    assign key       = is_lookup ? tpa_reg : spa_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b0;
            proto_type_reg <= '0;
            my_paddr_reg   <= '0;
            my_hwaddr_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_ENABLED:    enabled_reg    <= cfg_wdata[0];
                CFG_PROTO_TYPE: proto_type_reg <= cfg_wdata[PROTO_W-1:0];
                CFG_MY_PADDR:   my_paddr_reg   <= cfg_wdata[31:0];
                CFG_MY_HWADDR:  my_hwaddr_reg  <= cfg_wdata;
                default:        enabled_reg    <= enabled_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= req_t'(req_type);
            fproto_reg <= frame_proto;
            spa_reg    <= sender_paddr;
            shw_reg    <= sender_hw;
            tpa_reg    <= target_paddr;
            thw_reg    <= target_hw;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        action_next    = action_reg;
        hw_out_next    = hw_out_reg;
        pa_out_next    = pa_out_reg;
        use_clock_next = use_clock_reg;
        rd_idx_next    = rd_idx_reg;
        rd_vld_next    = 1'b0;
        rd_k_next      = rd_k_reg;
        mem_we         = 1'b0;
        mem_waddr      = scan_match_idx;
        mem_wpaddr     = key;
        mem_whw        = shw_reg;
        mem_wstamp     = scan_match_stamp;
        mem_re         = 1'b0;
        scan_ctl.clr   = 1'b0;
        scan_ctl.vld   = rd_vld_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                rd_idx_next  = '0;
                scan_ctl.clr = 1'b1;
                hw_out_next  = '0;
                pa_out_next  = '0;
                done_next    = 1'b1;
                state_next   = S_IDLE;
                if (is_lookup)
                begin
                    if (!enabled_reg)
                    begin
                        action_next = ACT_DISABLED;
                    end
                    else if (tpa_reg == '0)
                    begin
                        action_next = ACT_MISS;
                    end
                    else if (tpa_reg == mine)
                    begin
                        action_next    = ACT_HIT;
                        hw_out_next    = mine_hw;
                        use_clock_next = use_clock_reg + 1'b1;
                    end
                    else
                    begin
                        done_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                end
                else if (!(enabled_reg && fproto_reg == proto_type_reg && tpa_reg == mine))
                begin
                    action_next = ACT_DROP;
                end
                else if (spa_reg == mine)
                begin
                    action_next = ACT_SPOOF;
                end
                else if (req_reg == REQ_REPLY && thw_reg != mine_hw)
                begin
                    action_next = ACT_DROP;
                end
                else
                begin
                    done_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                mem_re      = 1'b1;
                rd_vld_next = 1'b1;
                rd_k_next   = rd_idx_reg;
                if (rd_idx_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                // last read beat lands in the scan unit on this edge
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                done_next   = 1'b1;
                state_next  = S_IDLE;
                hw_out_next = '0;
                pa_out_next = '0;
                if (is_lookup)
                begin
                    if (scan_found)
                    begin
                        use_clock_next = use_clock_reg + 1'b1;
                        mem_we         = 1'b1;
                        mem_whw        = scan_match_hw;
                        mem_wstamp     = use_clock_reg + 1'b1;
                        action_next    = ACT_HIT;
                        hw_out_next    = scan_match_hw;
                    end
                    else
                    begin
                        action_next = ACT_MISS;
                        pa_out_next = tpa_reg;
                    end
                end
                else
                begin
                    mem_we = 1'b1;
                    // a known sender only refreshes its hardware address
                    if (!scan_found)
                    begin
                        use_clock_next = use_clock_reg + 1'b1;
                        mem_waddr      = scan_pick_idx;
                        mem_wstamp     = use_clock_reg + 1'b1;
                    end
                    if (req_reg == REQ_REQUEST)
                    begin
                        action_next = ACT_REPLY;
                        hw_out_next = shw_reg;
                        pa_out_next = spa_reg;
                    end
                    else
                    begin
                        action_next = ACT_LEARNED;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            action_reg    <= ACT_DROP;
            hw_out_reg    <= '0;
            pa_out_reg    <= '0;
            use_clock_reg <= '0;
            rd_idx_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            rd_k_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            action_reg    <= action_next;
            hw_out_reg    <= hw_out_next;
            pa_out_reg    <= pa_out_next;
            use_clock_reg <= use_clock_next;
            rd_idx_reg    <= rd_idx_next;
            rd_vld_reg    <= rd_vld_next;
            rd_k_reg      <= rd_k_next;
        end
    end

    acl_store #(
        .ENTRIES    (ENTRIES),
        .PADDR_BITS (PADDR_BITS),
        .HW_BITS    (HW_BITS)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wpaddr (mem_wpaddr),
        .whw    (mem_whw),
        .wstamp (mem_wstamp),
        .re     (mem_re),
        .raddr  (rd_idx_reg),
        .rpaddr (rpaddr),
        .rhw    (rhw),
        .rstamp (rstamp)
    );

    acl_scan #(
        .ENTRIES    (ENTRIES),
        .PADDR_BITS (PADDR_BITS),
        .HW_BITS    (HW_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .k           (rd_k_reg),
        .key         (key),
        .use_clock   (use_clock_reg),
        .rpaddr      (rpaddr),
        .rhw         (rhw),
        .rstamp      (rstamp),
        .found       (scan_found),
        .match_idx   (scan_match_idx),
        .match_hw    (scan_match_hw),
        .match_stamp (scan_match_stamp),
        .pick_idx    (scan_pick_idx)
    );

    assign done      = done_reg;
    assign action    = action_reg;
    assign hw_addr   = hw_out_reg;
    assign paddr_out = pa_out_reg;

endmodule

FILE: rtl/acl_checker.sv
`timescale 1ns / 1ps

module acl_checker #(
    parameter int PADDR_BITS = acl_pkg::PADDR_BITS_DEF,
    parameter int HW_BITS    = acl_pkg::HW_BITS_DEF
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input logic [acl_pkg::ACT_W-1:0] action,
    input logic [HW_BITS-1:0]        hw_addr,
    input logic [PADDR_BITS-1:0]     paddr_out
);
    import acl_pkg::*;

    // an accepted beat keeps the block busy into the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    // hardware address only carries data for a hit or a reply
    a_hw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && action != ACT_HIT && action != ACT_REPLY) |-> (hw_addr == '0))
        else $error("hw_addr not zero for this action");

    a_pa_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && action != ACT_MISS && action != ACT_REPLY) |-> (paddr_out == '0))
        else $error("paddr_out not zero for this action");

endmodule

bind arp_cache_lru_responder_top acl_checker #(
    .PADDR_BITS (PADDR_BITS),
    .HW_BITS    (HW_BITS)
) u_acl_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import acl_pkg::*;

    localparam int NUM_ENTRIES    = ENTRIES_DEF;
    localparam int PA_W           = PADDR_BITS_DEF;
    localparam int HW_W           = HW_BITS_DEF;
    localparam int SETTLE_CYCLES  = ENTRIES_DEF + 5;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int POOL_MAX       = 40;
    localparam int REPORT_MAX     = 10;

    localparam logic [PROTO_W-1:0] PROTO_IP = 16'h0800;
    localparam logic [PA_W-1:0]    MY_PA    = 32'h0A00_0001;
    localparam logic [HW_W-1:0]    MY_HW    = 48'h0200_0000_0001;

    typedef struct {
        req_t                kind;
        logic [PROTO_W-1:0]  proto;
        logic [PA_W-1:0]     spa;
        logic [HW_W-1:0]     shw;
        logic [PA_W-1:0]     tpa;
        logic [HW_W-1:0]     thw;
    } arp_item_t;

    typedef struct {
        action_t             act;
        logic [HW_W-1:0]     hw;
        logic [PA_W-1:0]     pa;
    } arp_answer_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [REQ_W-1:0]     req_type;
    logic [PROTO_W-1:0]   frame_proto;
    logic [PA_W-1:0]      sender_paddr;
    logic [HW_W-1:0]      sender_hw;
    logic [PA_W-1:0]      target_paddr;
    logic [HW_W-1:0]      target_hw;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 done;
    logic [ACT_W-1:0]     action;
    logic [HW_W-1:0]      hw_addr;
    logic [PA_W-1:0]      paddr_out;

    // cache image and register copies kept by the predictor
    logic [PA_W-1:0]      cache_pa    [NUM_ENTRIES];
    logic [HW_W-1:0]      cache_hw    [NUM_ENTRIES];
    logic [31:0]          cache_stamp [NUM_ENTRIES];
    logic [31:0]          use_count;
    logic                 cfg_en;
    logic [PROTO_W-1:0]   cfg_proto;
    logic [PA_W-1:0]      cfg_my_pa;
    logic [HW_W-1:0]      cfg_my_hw;

    arp_answer_t          answer_q [$];
    logic [PA_W-1:0]      addr_pool [POOL_MAX];
    int                   pool_size;
    int                   mismatch_count;
    int                   stall_cycles;

    arp_cache_lru_responder_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .frame_proto  (frame_proto),
        .sender_paddr (sender_paddr),
        .sender_hw    (sender_hw),
        .target_paddr (target_paddr),
        .target_hw    (target_hw),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .action       (action),
        .hw_addr      (hw_addr),
        .paddr_out    (paddr_out)
    );

    always #1 clk = ~clk;

    function automatic arp_answer_t resolve_item(input arp_item_t it);
        arp_answer_t r;
        int          k;
        int          pick;
        bit          found;
        logic [31:0] age_k;
        logic [31:0] age_pick;
        r.act = ACT_DROP;
        r.hw  = '0;
        r.pa  = '0;
        found = 1'b0;
        pick  = 0;
        if (it.kind == REQ_LOOKUP)
        begin
            if (!cfg_en)
                r.act = ACT_DISABLED;
            else if (it.tpa == '0)
                r.act = ACT_MISS;
            else if (it.tpa == cfg_my_pa)
            begin
                use_count = use_count + 1;
                r.act = ACT_HIT;
                r.hw  = cfg_my_hw;
            end
            else
            begin
                r.act = ACT_MISS;
                r.pa  = it.tpa;
                for (k = 0; k < NUM_ENTRIES; k++)
                begin
                    if (!found && cache_pa[k] == it.tpa)
                    begin
                        found = 1'b1;
                        use_count = use_count + 1;
                        cache_stamp[k] = use_count;
                        r.act = ACT_HIT;
                        r.hw  = cache_hw[k];
                        r.pa  = '0;
                    end
                end
            end
        end
        else if (cfg_en && it.proto == cfg_proto && it.tpa == cfg_my_pa)
        begin
            if (it.spa == cfg_my_pa)
                r.act = ACT_SPOOF;
            else if (it.kind == REQ_REPLY && it.thw != cfg_my_hw)
                r.act = ACT_DROP;
            else
            begin
                // known sender: refresh hw only; empty slots passed on the way get restamped
                for (k = 0; k < NUM_ENTRIES; k++)
                begin
                    if (!found)
                    begin
                        age_k    = use_count - cache_stamp[k];
                        age_pick = use_count - cache_stamp[pick];
                        if (cache_pa[k] == it.spa)
                        begin
                            cache_hw[k] = it.shw;
                            found = 1'b1;
                        end
                        else if (cache_pa[k] == '0)
                        begin
                            pick = k;
                            cache_stamp[k] = use_count + 1;
                        end
                        else if (age_k > age_pick)
                            pick = k;
                    end
                end
                if (!found)
                begin
                    use_count = use_count + 1;
                    cache_stamp[pick] = use_count;
                    cache_pa[pick] = it.spa;
                    cache_hw[pick] = it.shw;
                end
                if (it.kind == REQ_REQUEST)
                begin
                    r.act = ACT_REPLY;
                    r.hw  = it.shw;
                    r.pa  = it.spa;
                end
                else
                    r.act = ACT_LEARNED;
            end
        end
        return r;
    endfunction

    function automatic logic [HW_W-1:0] rand_hw();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[HW_W-1:0];
    endfunction

    function automatic arp_item_t mk_item(input req_t kind, input logic [PROTO_W-1:0] proto,
                                          input logic [PA_W-1:0] spa,
                                          input logic [HW_W-1:0] shw,
                                          input logic [PA_W-1:0] tpa,
                                          input logic [HW_W-1:0] thw);
        arp_item_t it;
        it.kind  = kind;
        it.proto = proto;
        it.spa   = spa;
        it.shw   = shw;
        it.tpa   = tpa;
        it.thw   = thw;
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic arp_item_t make_traffic();
        arp_item_t it;
        int        r;
        it.kind  = req_t'($urandom_range(0, 3));
        it.proto = PROTO_W'($urandom_range(0, 16'hFFFF));
        it.spa   = $urandom();
        it.shw   = rand_hw();
        it.tpa   = $urandom();
        it.thw   = rand_hw();
        // a few beats stay pure noise, the rest look like real traffic
        if ($urandom_range(0, 99) >= 8)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                it.kind = REQ_LOOKUP;
            else if (r < 68)
                it.kind = REQ_REQUEST;
            else if (r < 93)
                it.kind = REQ_REPLY;
            else
                it.kind = REQ_OTHER;
            if ($urandom_range(0, 9) != 0)
                it.proto = cfg_proto;
            if ($urandom_range(0, 9) != 0)
                it.tpa = cfg_my_pa;
            r = $urandom_range(0, 99);
            if (r < 4)
                it.spa = cfg_my_pa;
            else if (r < 6)
                it.spa = '0;
            else
                it.spa = addr_pool[$urandom_range(0, pool_size - 1)];
            if (it.kind == REQ_REPLY && $urandom_range(0, 6) != 0)
                it.thw = cfg_my_hw;
            if (it.kind == REQ_LOOKUP)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    it.tpa = addr_pool[$urandom_range(0, pool_size - 1)];
                else if (r < 88)
                    it.tpa = cfg_my_pa;
                else if (r < 92)
                    it.tpa = '0;
                else
                    it.tpa = $urandom();
            end
        end
        return it;
    endfunction

    task automatic send_item(input arp_item_t it, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start        <= 1'b1;
        req_type     <= it.kind;
        frame_proto  <= it.proto;
        sender_paddr <= it.spa;
        sender_hw    <= it.shw;
        target_paddr <= it.tpa;
        target_hw    <= it.thw;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        answer_q.push_back(resolve_item(it));
    endtask

    task automatic apply_settings(input logic en, input logic [PROTO_W-1:0] proto,
                                  input logic [PA_W-1:0] pa, input logic [HW_W-1:0] hw);
        @(negedge clk);
        start <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_ENABLED;
        cfg_wdata <= CFG_W'(en);
        @(negedge clk);
        cfg_idx   <= CFG_PROTO_TYPE;
        cfg_wdata <= CFG_W'(proto);
        @(negedge clk);
        cfg_idx   <= CFG_MY_PADDR;
        cfg_wdata <= CFG_W'(pa);
        @(negedge clk);
        cfg_idx   <= CFG_MY_HWADDR;
        cfg_wdata <= CFG_W'(hw);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_en    = en;
        cfg_proto = proto;
        cfg_my_pa = pa;
        cfg_my_hw = hw;
    endtask

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // registers still at reset: channel off
    task automatic test_reset_state();
        send_item(mk_item(REQ_LOOKUP, '0, '0, '0, 32'h0A00_0005, '0), 0);
        send_item(mk_item(REQ_REQUEST, '0, 32'h0A00_0007, 48'h1, '0, '0), 1);
    endtask

    task automatic test_lookup_paths();
        apply_settings(1'b1, PROTO_IP, MY_PA, MY_HW);
        send_item(mk_item(REQ_LOOKUP, '0, '0, '0, '0, '0), 0);
        send_item(mk_item(REQ_LOOKUP, '0, '0, '0, MY_PA, '0), 0);
        send_item(mk_item(REQ_LOOKUP, '0, '0, '0, 32'h0A00_0002, '0), 2);
    endtask

    task automatic test_frame_checks();
        send_item(mk_item(REQ_REQUEST, 16'h86DD, 32'h0A00_0010, 48'h11, MY_PA, '0), 0);
        send_item(mk_item(REQ_REQUEST, PROTO_IP, 32'h0A00_0010, 48'h11, 32'h0A00_0099, '0), 0);
        send_item(mk_item(REQ_REQUEST, PROTO_IP, MY_PA, 48'h22, MY_PA, '0), 1);
        send_item(mk_item(REQ_REPLY, PROTO_IP, 32'h0A00_0011, 48'h33, MY_PA, 48'h5), 0);
        send_item(mk_item(REQ_OTHER, PROTO_IP, 32'h0A00_0012, 48'h44, MY_PA, '0), 3);
    endtask

    task automatic test_learning();
        send_item(mk_item(REQ_REQUEST, PROTO_IP, 32'h0A00_0020, 48'hA1A1_0000_0001, MY_PA, '0), 0);
        send_item(mk_item(REQ_LOOKUP, '0, '0, '0, 32'h0A00_0020, '0), 0);
        // same sender again overwrites its hw in place
        send_item(mk_item(REQ_REPLY, PROTO_IP, 32'h0A00_0020, 48'hB2B2_0000_0002, MY_PA, MY_HW), 0);
        send_item(mk_item(REQ_LOOKUP, '0, '0, '0, 32'h0A00_0020, '0), 1);
        // sender zero lands on the first empty slot, which stays empty
        send_item(mk_item(REQ_REQUEST, PROTO_IP, '0, 48'hC3C3_0000_0003, MY_PA, '0), 0);
        send_item(mk_item(REQ_LOOKUP, '0, '0, '0, '0, '0), 0);
        send_item(mk_item(REQ_REQUEST, PROTO_IP, '1, '1, MY_PA, '1), 0);
        send_item(mk_item(REQ_LOOKUP, '0, '1, '1, '1, '1), 0);
    endtask

    task automatic test_random_traffic(input int count, input int n_addr);
        int n;
        int gap;
        pool_size = n_addr;
        for (n = 0; n < pool_size; n++)
        begin
            addr_pool[n] = $urandom();
            if (addr_pool[n] == '0)
                addr_pool[n] = 32'h1;
        end
        for (n = 0; n < count; n++)
        begin
            // some stretches run back to back with no idle cycles
            gap = ((n % 150) < 40) ? 0 : pick_gap();
            send_item(make_traffic(), gap);
        end
    endtask

    always @(posedge clk)
    begin : check_answers
        arp_answer_t want;
        if (rst_n && done)
        begin
            if (answer_q.size() == 0)
                note_failure($sformatf("unexpected result act %0d hw %h pa %h",
                                       action, hw_addr, paddr_out));
            else
            begin
                want = answer_q.pop_front();
                if (action !== want.act || hw_addr !== want.hw || paddr_out !== want.pa)
                    note_failure($sformatf("exp act %0d hw %h pa %h, got act %0d hw %h pa %h",
                                           want.act, want.hw, want.pa,
                                           action, hw_addr, paddr_out));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** arp_cache_lru_responder_top: FAILED **");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int k;
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        req_type       = '0;
        frame_proto    = '0;
        sender_paddr   = '0;
        sender_hw      = '0;
        target_paddr   = '0;
        target_hw      = '0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_ENABLED;
        cfg_wdata      = '0;
        mismatch_count = 0;
        stall_cycles   = 0;
        pool_size      = 1;
        for (k = 0; k < NUM_ENTRIES; k++)
        begin
            cache_pa[k]    = '0;
            cache_hw[k]    = '0;
            cache_stamp[k] = '0;
        end
        use_count = '0;
        cfg_en    = 1'b0;
        cfg_proto = '0;
        cfg_my_pa = '0;
        cfg_my_hw = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_lookup_paths();
        test_frame_checks();
        test_learning();

        apply_settings(1'b1, PROTO_IP, 32'hC0A8_0001, rand_hw());
        test_random_traffic(400, 20);
        apply_settings(1'b1, 16'hFFFF, '1, '1);
        test_random_traffic(300, 30);
        apply_settings(1'b1, '0, '0, '0);
        test_random_traffic(300, 12);
        apply_settings(1'b0, PROTO_W'($urandom_range(0, 16'hFFFF)), $urandom(), rand_hw());
        test_random_traffic(100, 20);
        apply_settings(1'b1, PROTO_W'($urandom_range(0, 16'hFFFF)), $urandom(), rand_hw());
        test_random_traffic(400, 24);

        @(negedge clk);
        start <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && answer_q.size() == 0)
            $display("** arp_cache_lru_responder_top: PASSED **");
        else
            $display("** arp_cache_lru_responder_top: FAILED **");
        $finish;
    end

endmodule
